@@ sv/stok_pkg.sv @@
package stok_pkg;

  localparam int unsigned NAME_LIMIT  = 32;
  localparam int unsigned ERROR_LIMIT = 64;

  localparam logic [5:0]  TOKEN_LIMIT = 6'(NAME_LIMIT - 1);
  localparam logic [6:0]  ERR_LIMIT   = 7'(ERROR_LIMIT);
  localparam logic [23:0] POS_MAX     = 24'hFF_FFFF;
  localparam logic [15:0] LINE_MAX    = 16'hFFFF;
  localparam logic [15:0] MAX_TOKENS_RESET = 16'd4096;
  localparam logic [5:0]  KW_ALL      = 6'h3F;
  localparam int unsigned KW_COUNT    = 6;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_IDENT    = 5'd1;
  localparam logic [4:0] KIND_NUMBER   = 5'd2;
  localparam logic [4:0] KIND_FUNC     = 5'd3;
  localparam logic [4:0] KIND_EQ       = 5'd9;
  localparam logic [4:0] KIND_NE       = 5'd10;
  localparam logic [4:0] KIND_LE       = 5'd11;
  localparam logic [4:0] KIND_GE       = 5'd12;
  localparam logic [4:0] KIND_PLUS     = 5'd13;
  localparam logic [4:0] KIND_MINUS    = 5'd14;
  localparam logic [4:0] KIND_AND      = 5'd15;
  localparam logic [4:0] KIND_OR       = 5'd16;
  localparam logic [4:0] KIND_XOR      = 5'd17;
  localparam logic [4:0] KIND_LT       = 5'd18;
  localparam logic [4:0] KIND_GT       = 5'd19;
  localparam logic [4:0] KIND_ASSIGN   = 5'd20;
  localparam logic [4:0] KIND_LPAREN   = 5'd21;
  localparam logic [4:0] KIND_RPAREN   = 5'd22;
  localparam logic [4:0] KIND_LBRACE   = 5'd23;
  localparam logic [4:0] KIND_RBRACE   = 5'd24;
  localparam logic [4:0] KIND_COMMA    = 5'd25;
  localparam logic [4:0] KIND_SEMI     = 5'd26;
  localparam logic [4:0] KIND_BAD      = 5'd27;
  localparam logic [4:0] KIND_OVERFLOW = 5'd28;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic [5:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: return 6'd4;
      3'd1: return 6'd3;
      3'd2: return 6'd2;
      3'd3: return 6'd4;
      3'd4: return 6'd5;
      3'd5: return 6'd6;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [5:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    case (k)
      3'd0: begin
        case (idx)
          6'd0: ch = "f";
          6'd1: ch = "u";
          6'd2: ch = "n";
          6'd3: ch = "c";
          default: ch = CH_NUL;
        endcase
      end
      3'd1: begin
        case (idx)
          6'd0: ch = "v";
          6'd1: ch = "a";
          6'd2: ch = "r";
          default: ch = CH_NUL;
        endcase
      end
      3'd2: begin
        case (idx)
          6'd0: ch = "i";
          6'd1: ch = "f";
          default: ch = CH_NUL;
        endcase
      end
      3'd3: begin
        case (idx)
          6'd0: ch = "e";
          6'd1: ch = "l";
          6'd2: ch = "s";
          6'd3: ch = "e";
          default: ch = CH_NUL;
        endcase
      end
      3'd4: begin
        case (idx)
          6'd0: ch = "w";
          6'd1: ch = "h";
          6'd2: ch = "i";
          6'd3: ch = "l";
          6'd4: ch = "e";
          default: ch = CH_NUL;
        endcase
      end
      3'd5: begin
        case (idx)
          6'd0: ch = "r";
          6'd1: ch = "e";
          6'd2: ch = "t";
          6'd3: ch = "u";
          6'd4: ch = "r";
          6'd5: ch = "n";
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "&": return KIND_AND;
      "|": return KIND_OR;
      "^": return KIND_XOR;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      ",": return KIND_COMMA;
      ";": return KIND_SEMI;
      default: return KIND_END;
    endcase
  endfunction

endpackage

@@ sv/source_tokenizer_core.sv @@
// Streaming tokenizer for a small C-like language.
// Source bytes enter on the input channel (in_valid_i, in_ready_o, ch_i, last_i), one
// request per byte. Tokens and errors leave on the output channel (out_valid_o,
// out_ready_i) as requests with kind, line, start offset, length and offending byte;
// final_res_o marks the last result caused by one input byte.
// Each byte is lexed in the cycle it is accepted and its results, up to three, are
// loaded into a three-entry result buffer; the first result is visible the next cycle.
// The buffer drains one result per cycle while the receiver is ready, so a byte that
// causes at most one result is accepted every cycle. A new byte is accepted while the
// last buffered result is being taken. When the receiver stalls, the buffer holds its
// results and the input is not accepted once the buffer holds a result that is not
// being taken. The token limit is written through cfg_wr_en_i and cfg_wr_data_i;
// the user must write it only while idle, which the block does not enforce. Reset
// returns the scanner to the start of a new source and sets the token limit to 4096;
// a zero byte or a byte flagged last ends the current source.
module source_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  kind_o,
  output logic [15:0] line_o,
  output logic [23:0] start_res_o,
  output logic [5:0]  length_o,
  output logic [7:0]  bad_char_o,
  output logic        final_res_o
);

  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_DEC,
    M_HEX,
    M_OP,
    M_COMMENT,
    M_HALT
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  pend;
    logic [5:0]  tlen;
    logic [23:0] tstart;
    logic [23:0] pos;
    logic [15:0] line;
    logic [5:0]  kwm;
    logic [15:0] temit;
    logic [6:0]  errs;
  } scan_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [23:0] start;
    logic [5:0]  len;
    logic [7:0]  bad;
  } res_t;

  typedef struct packed {
    res_t [2:0] r;
    logic [1:0] n;
  } res_list_t;

  localparam scan_t SCAN_RESET = '{
    mode:   M_IDLE,
    pend:   8'd0,
    tlen:   6'd0,
    tstart: 24'd0,
    pos:    24'd0,
    line:   16'd1,
    kwm:    stok_pkg::KW_ALL,
    temit:  16'd0,
    errs:   7'd0
  };

  function automatic void put(inout res_list_t o, input scan_t s, input logic [4:0] kind,
                              input logic [23:0] start, input logic [5:0] len,
                              input logic [7:0] bad);
    if (o.n != 2'd3) begin
      o.r[o.n] = '{kind: kind, line: s.line, start: start, len: len, bad: bad};
      o.n = o.n + 2'd1;
    end
  endfunction

  function automatic void report(inout res_list_t o, inout scan_t s, input logic [4:0] kind,
                                 input logic [23:0] start, input logic [5:0] len,
                                 input logic [7:0] bad);
    if (s.errs < stok_pkg::ERR_LIMIT) begin
      s.errs = s.errs + 7'd1;
      put(o, s, kind, start, len, bad);
    end
  endfunction

  function automatic logic emit_token(inout res_list_t o, inout scan_t s,
                                      input logic [15:0] maxt, input logic [4:0] kind,
                                      input logic [23:0] start, input logic [5:0] len);
    if ({1'b0, s.temit} + 17'd1 >= {1'b0, maxt}) begin
      report(o, s, stok_pkg::KIND_OVERFLOW, start, 6'd0, 8'd0);
      s.mode = M_HALT;
      return 1'b0;
    end
    put(o, s, kind, start, len, 8'd0);
    s.temit = s.temit + 16'd1;
    return 1'b1;
  endfunction

  function automatic void kw_update(inout scan_t s, input logic [7:0] c,
                                    input logic [5:0] idx);
    for (int k = 0; k < stok_pkg::KW_COUNT; k++) begin
      if (idx >= stok_pkg::kw_len(3'(k)) || stok_pkg::kw_char(3'(k), idx) != c) begin
        s.kwm[k] = 1'b0;
      end
    end
  endfunction

  function automatic logic [4:0] ident_kind(input scan_t s);
    logic [4:0] kind;
    kind = stok_pkg::KIND_IDENT;
    for (int k = stok_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (s.kwm[k] && stok_pkg::kw_len(3'(k)) == s.tlen) begin
        kind = stok_pkg::KIND_FUNC + 5'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic finish_token(inout res_list_t o, inout scan_t s,
                                        input logic [15:0] maxt);
    logic [4:0] kind;
    logic       ok;
    if (s.mode == M_OP) begin
      if (s.pend == "/" || s.pend == "!") begin
        report(o, s, stok_pkg::KIND_BAD, s.tstart, 6'd1, s.pend);
        s.mode = M_IDLE;
        return 1'b1;
      end
      kind = (s.pend == "=") ? stok_pkg::KIND_ASSIGN :
             (s.pend == "<") ? stok_pkg::KIND_LT : stok_pkg::KIND_GT;
      ok = emit_token(o, s, maxt, kind, s.tstart, 6'd1);
    end else begin
      kind = (s.mode == M_IDENT) ? ident_kind(s) : stok_pkg::KIND_NUMBER;
      ok = emit_token(o, s, maxt, kind, s.tstart, s.tlen);
    end
    if (ok) begin
      s.mode = M_IDLE;
    end
    s.kwm = stok_pkg::KW_ALL;
    s.tlen = 6'd0;
    return ok;
  endfunction

  function automatic void idle_byte(inout res_list_t o, inout scan_t s,
                                    input logic [15:0] maxt, input logic [7:0] c);
    logic [4:0] kind;
    kind = stok_pkg::single_kind(c);
    if (c == stok_pkg::CH_LF) begin
      if (s.line != stok_pkg::LINE_MAX) begin
        s.line = s.line + 16'd1;
      end
    end else if (stok_pkg::is_space(c)) begin
      s.mode = s.mode;
    end else if (stok_pkg::is_alpha(c) || c == "_") begin
      s.mode = M_IDENT;
      s.tstart = s.pos;
      s.kwm = stok_pkg::KW_ALL;
      kw_update(s, c, 6'd0);
      s.tlen = 6'd1;
    end else if (stok_pkg::is_digit(c)) begin
      s.mode = M_DEC;
      s.tstart = s.pos;
      s.pend = c;
      s.tlen = 6'd1;
    end else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">") begin
      s.mode = M_OP;
      s.tstart = s.pos;
      s.pend = c;
    end else if (kind != stok_pkg::KIND_END) begin
      void'(emit_token(o, s, maxt, kind, s.pos, 6'd1));
    end else begin
      report(o, s, stok_pkg::KIND_BAD, s.pos, 6'd1, c);
    end
  endfunction

  function automatic void step_byte(inout res_list_t o, inout scan_t s,
                                    input logic [15:0] maxt, input logic [7:0] c);
    logic       brk;
    logic [4:0] kind;
    brk = 1'b0;
    kind = stok_pkg::KIND_GT;
    case (s.mode)
      M_HALT: begin
        brk = 1'b0;
      end
      M_COMMENT: begin
        if (c == stok_pkg::CH_LF) begin
          s.mode = M_IDLE;
          idle_byte(o, s, maxt, c);
        end
      end
      M_IDENT: begin
        if (stok_pkg::is_name(c) && s.tlen < stok_pkg::TOKEN_LIMIT) begin
          kw_update(s, c, s.tlen);
          s.tlen = s.tlen + 6'd1;
        end else begin
          brk = 1'b1;
        end
      end
      M_DEC: begin
        if (s.tlen == 6'd1 && s.pend == "0" && (c == "x" || c == "X")) begin
          s.mode = M_HEX;
          s.tlen = 6'd2;
        end else if (stok_pkg::is_digit(c) && s.tlen < stok_pkg::TOKEN_LIMIT) begin
          s.tlen = s.tlen + 6'd1;
        end else begin
          brk = 1'b1;
        end
      end
      M_HEX: begin
        if (stok_pkg::is_xdigit(c) && s.tlen < stok_pkg::TOKEN_LIMIT) begin
          s.tlen = s.tlen + 6'd1;
        end else begin
          brk = 1'b1;
        end
      end
      M_OP: begin
        if (s.pend == "/" && c == "/") begin
          s.mode = M_COMMENT;
        end else if (s.pend != "/" && c == "=") begin
          if (s.pend == "=") begin
            kind = stok_pkg::KIND_EQ;
          end else if (s.pend == "!") begin
            kind = stok_pkg::KIND_NE;
          end else if (s.pend == "<") begin
            kind = stok_pkg::KIND_LE;
          end else begin
            kind = stok_pkg::KIND_GE;
          end
          if (emit_token(o, s, maxt, kind, s.tstart, 6'd2)) begin
            s.mode = M_IDLE;
          end
        end else begin
          brk = 1'b1;
        end
      end
      default: begin
        s.mode = M_IDLE;
        idle_byte(o, s, maxt, c);
      end
    endcase
    if (brk) begin
      if (finish_token(o, s, maxt)) begin
        idle_byte(o, s, maxt, c);
      end
    end
  endfunction

  function automatic void end_source(inout res_list_t o, inout scan_t s,
                                     input logic [15:0] maxt);
    if (s.mode == M_IDENT || s.mode == M_DEC || s.mode == M_HEX || s.mode == M_OP) begin
      void'(finish_token(o, s, maxt));
    end
    if (s.mode != M_HALT) begin
      put(o, s, stok_pkg::KIND_END, s.pos, 6'd0, 8'd0);
    end
    s = SCAN_RESET;
  endfunction

  logic [15:0] max_tokens_q;
  scan_t       scan_q;
  scan_t       scan_d;
  res_list_t   list_d;
  res_t [2:0]  res_q;
  logic [1:0]  cnt_q;
  logic [1:0]  rd_q;
  logic        rd_last;
  logic        in_fire;
  logic        out_fire;
  res_t        res_head;

  always_comb begin
    scan_d = scan_q;
    list_d = '0;
    if (ch_i == stok_pkg::CH_NUL) begin
      end_source(list_d, scan_d, max_tokens_q);
    end else begin
      step_byte(list_d, scan_d, max_tokens_q, ch_i);
      if (scan_d.pos != stok_pkg::POS_MAX) begin
        scan_d.pos = scan_d.pos + 24'd1;
      end
      if (last_i) begin
        end_source(list_d, scan_d, max_tokens_q);
      end
    end
  end

  assign rd_last     = (rd_q + 2'd1) == cnt_q;
  assign out_valid_o = rd_q != cnt_q;
  assign in_ready_o  = (cnt_q == 2'd0) || (rd_last && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= stok_pkg::MAX_TOKENS_RESET;
      scan_q       <= SCAN_RESET;
      cnt_q        <= 2'd0;
      rd_q         <= 2'd0;
    end else begin
      if (cfg_wr_en_i) begin
        max_tokens_q <= cfg_wr_data_i;
      end
      if (in_fire) begin
        scan_q <= scan_d;
        cnt_q  <= list_d.n;
        rd_q   <= 2'd0;
      end else if (out_fire) begin
        if (rd_last) begin
          cnt_q <= 2'd0;
          rd_q  <= 2'd0;
        end else begin
          rd_q <= rd_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= list_d.r;
    end
  end

  assign res_head    = res_q[rd_q];
  assign kind_o      = res_head.kind;
  assign line_o      = res_head.line;
  assign start_res_o = res_head.start;
  assign length_o    = res_head.len;
  assign bad_char_o  = res_head.bad;
  assign final_res_o = rd_last;

endmodule

@@ test/source_tokenizer_core_test.sv @@
module source_tokenizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NAME, SCAN_DEC, SCAN_HEX, SCAN_OP, SCAN_COMMENT, SCAN_HALT
  } scan_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [23:0] start;
    logic [5:0]  len;
    logic [7:0]  bad;
    logic        fin;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  logic [7:0]  ch = 8'h00;
  logic        last = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [4:0]  kind_o;
  logic [15:0] line_o;
  logic [23:0] start_res_o;
  logic [5:0]  length_o;
  logic [7:0]  bad_char_o;
  logic        final_res_o;

  int in_idle_pct = 13;
  int out_idle_pct = 13;
  int failures = 0;
  int live_bytes = 0;

  string kw_word [6] = '{"func", "var", "if", "else", "while", "return"};
  string name_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string hex_pool = "0123456789abcdefABCDEF";
  string op_pool = "=!<>/+-&|^(){},;";

  logic [15:0] tok_limit;
  scan_e       scan;
  logic [7:0]  held_ch;
  logic [5:0]  word_len;
  logic [23:0] word_start;
  logic [23:0] src_pos;
  logic [15:0] src_line;
  logic [5:0]  kw_alive;
  logic [15:0] tok_count;
  logic [6:0]  err_count;
  token_t      step_out[$];
  token_t      expected_tokens[$];

  source_tokenizer_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch),
    .last_i       (last),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .kind_o       (kind_o),
    .line_o       (line_o),
    .start_res_o  (start_res_o),
    .length_o     (length_o),
    .bad_char_o   (bad_char_o),
    .final_res_o  (final_res_o)
  );

  always #6 clk = ~clk;

  function automatic bit letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hexdigit(input logic [7:0] c);
    return decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit name_char(input logic [7:0] c);
    return letter(c) || decimal(c) || c == "_";
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    case (c)
      "+": return stok_pkg::KIND_PLUS;
      "-": return stok_pkg::KIND_MINUS;
      "&": return stok_pkg::KIND_AND;
      "|": return stok_pkg::KIND_OR;
      "^": return stok_pkg::KIND_XOR;
      "(": return stok_pkg::KIND_LPAREN;
      ")": return stok_pkg::KIND_RPAREN;
      "{": return stok_pkg::KIND_LBRACE;
      "}": return stok_pkg::KIND_RBRACE;
      ",": return stok_pkg::KIND_COMMA;
      ";": return stok_pkg::KIND_SEMI;
      default: return stok_pkg::KIND_END;
    endcase
  endfunction

  function automatic void source_restart();
    scan = SCAN_IDLE;
    held_ch = stok_pkg::CH_NUL;
    word_len = 6'd0;
    word_start = 24'd0;
    src_pos = 24'd0;
    src_line = 16'd1;
    kw_alive = stok_pkg::KW_ALL;
    tok_count = 16'd0;
    err_count = 7'd0;
  endfunction

  function automatic void add_result(input logic [4:0] kind, input logic [23:0] start,
                                     input logic [5:0] len, input logic [7:0] bad);
    token_t t;
    if (step_out.size() >= 3) return;
    t.kind = kind;
    t.line = src_line;
    t.start = start;
    t.len = len;
    t.bad = bad;
    t.fin = 1'b0;
    step_out.push_back(t);
  endfunction

  function automatic void add_error(input logic [4:0] kind, input logic [23:0] start,
                                    input logic [5:0] len, input logic [7:0] bad);
    if (err_count >= stok_pkg::ERR_LIMIT) return;
    err_count++;
    add_result(kind, start, len, bad);
  endfunction

  function automatic bit add_token(input logic [4:0] kind, input logic [23:0] start,
                                   input logic [5:0] len);
    if (int'(tok_count) + 1 >= int'(tok_limit)) begin
      add_error(stok_pkg::KIND_OVERFLOW, start, 6'd0, 8'd0);
      scan = SCAN_HALT;
      return 1'b0;
    end
    add_result(kind, start, len, 8'd0);
    tok_count++;
    return 1'b1;
  endfunction

  function automatic void kw_narrow(input logic [7:0] c, input logic [5:0] idx);
    for (int k = 0; k < stok_pkg::KW_COUNT; k++) begin
      if (idx >= kw_word[k].len() || kw_word[k][idx] != c) kw_alive[k] = 1'b0;
    end
  endfunction

  function automatic logic [4:0] name_kind();
    for (int k = 0; k < stok_pkg::KW_COUNT; k++) begin
      if (kw_alive[k] && kw_word[k].len() == word_len) return stok_pkg::KIND_FUNC + 5'(k);
    end
    return stok_pkg::KIND_IDENT;
  endfunction

  function automatic bit finish_word();
    bit ok;
    logic [4:0] k;
    if (scan == SCAN_OP) begin
      if (held_ch == "/" || held_ch == "!") begin
        add_error(stok_pkg::KIND_BAD, word_start, 6'd1, held_ch);
        scan = SCAN_IDLE;
        return 1'b1;
      end
      k = held_ch == "=" ? stok_pkg::KIND_ASSIGN
        : held_ch == "<" ? stok_pkg::KIND_LT : stok_pkg::KIND_GT;
      ok = add_token(k, word_start, 6'd1);
    end else begin
      k = scan == SCAN_NAME ? name_kind() : stok_pkg::KIND_NUMBER;
      ok = add_token(k, word_start, word_len);
    end
    if (ok) scan = SCAN_IDLE;
    kw_alive = stok_pkg::KW_ALL;
    word_len = 6'd0;
    return ok;
  endfunction

  function automatic void idle_byte(input logic [7:0] c);
    logic [4:0] k;
    if (c == stok_pkg::CH_LF) begin
      if (src_line < stok_pkg::LINE_MAX) src_line++;
      return;
    end
    if (c == " " || c == stok_pkg::CH_TAB || c == stok_pkg::CH_VT ||
        c == stok_pkg::CH_FF || c == stok_pkg::CH_CR) return;
    if (letter(c) || c == "_") begin
      scan = SCAN_NAME;
      word_start = src_pos;
      kw_alive = stok_pkg::KW_ALL;
      kw_narrow(c, 6'd0);
      word_len = 6'd1;
      return;
    end
    if (decimal(c)) begin
      scan = SCAN_DEC;
      word_start = src_pos;
      held_ch = c;
      word_len = 6'd1;
      return;
    end
    if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">") begin
      scan = SCAN_OP;
      word_start = src_pos;
      held_ch = c;
      return;
    end
    k = punct_kind(c);
    if (k != stok_pkg::KIND_END) void'(add_token(k, src_pos, 6'd1));
    else add_error(stok_pkg::KIND_BAD, src_pos, 6'd1, c);
  endfunction

  function automatic void step_byte(input logic [7:0] c);
    logic [4:0] k;
    case (scan)
      SCAN_HALT: return;
      SCAN_COMMENT: begin
        if (c == stok_pkg::CH_LF) begin
          scan = SCAN_IDLE;
          idle_byte(c);
        end
        return;
      end
      SCAN_NAME: begin
        if (name_char(c) && word_len < stok_pkg::TOKEN_LIMIT) begin
          kw_narrow(c, word_len);
          word_len++;
          return;
        end
      end
      SCAN_DEC: begin
        if (word_len == 6'd1 && held_ch == "0" && (c == "x" || c == "X")) begin
          scan = SCAN_HEX;
          word_len = 6'd2;
          return;
        end
        if (decimal(c) && word_len < stok_pkg::TOKEN_LIMIT) begin
          word_len++;
          return;
        end
      end
      SCAN_HEX: begin
        if (hexdigit(c) && word_len < stok_pkg::TOKEN_LIMIT) begin
          word_len++;
          return;
        end
      end
      SCAN_OP: begin
        if (held_ch == "/" && c == "/") begin
          scan = SCAN_COMMENT;
          return;
        end
        if (held_ch != "/" && c == "=") begin
          k = held_ch == "=" ? stok_pkg::KIND_EQ : held_ch == "!" ? stok_pkg::KIND_NE
            : held_ch == "<" ? stok_pkg::KIND_LE : stok_pkg::KIND_GE;
          if (add_token(k, word_start, 6'd2)) scan = SCAN_IDLE;
          return;
        end
      end
      default: begin
        scan = SCAN_IDLE;
        idle_byte(c);
        return;
      end
    endcase
    if (!finish_word()) return;
    idle_byte(c);
  endfunction

  function automatic void end_source();
    if (scan == SCAN_NAME || scan == SCAN_DEC || scan == SCAN_HEX || scan == SCAN_OP) begin
      void'(finish_word());
    end
    if (scan != SCAN_HALT) add_result(stok_pkg::KIND_END, src_pos, 6'd0, 8'd0);
    source_restart();
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic l);
    step_out.delete();
    if (c == stok_pkg::CH_NUL) begin
      end_source();
    end else begin
      step_byte(c);
      if (src_pos < stok_pkg::POS_MAX) src_pos++;
      if (l) end_source();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].fin = 1'b1;
    foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tok_limit = cfg_wr_data;
      if (in_valid && in_ready_o === 1'b1) begin
        if (ch == stok_pkg::CH_NUL || scan != SCAN_HALT) live_bytes++;
        lex_byte(ch, last);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid_o === 1'b1 && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: kind mismatch, expected no request, actual %0d", $time, kind_o);
        failures++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("line", want.line, line_o);
        check_field("start_res", want.start, start_res_o);
        check_field("length", want.len, length_o);
        check_field("bad_char", want.bad, bad_char_o);
        check_field("final_res", want.fin, final_res_o);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic send_byte(input logic [7:0] c, input logic l);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    last <= l;
    @(posedge clk);
    while (in_ready_o !== 1'b1) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic l);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], l && i == s.len() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0 || out_valid_o === 1'b1) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_token_limit(input logic [15:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_token_kinds();
    send_text("func var if else while return funcs el _a9 Zq\n", 1'b0);
    send_text("0 42 0x 0XaF9 0x1g\n", 1'b0);
    send_text("== != <= >= + - & | ^ < > = ( ) { } , ;\n", 1'b0);
    send_text("a==b<c>=d!x/y // note \200 }\n", 1'b0);
    send_text("@ # $ \200 \377 \t\v\f\015 ~\n", 1'b0);
    send_byte(stok_pkg::CH_NUL, 1'b0);
  endtask

  task automatic test_long_words();
    repeat (33) send_byte("a", 1'b0);
    send_byte(" ", 1'b0);
    repeat (31) send_byte("x", 1'b0);
    send_text("while;", 1'b0);
    repeat (31) send_byte("9", 1'b0);
    send_text("0x5 0x", 1'b0);
    repeat (29) send_byte("F", 1'b0);
    send_text("Ab;", 1'b1);
  endtask

  task automatic test_source_ends();
    send_text("a", 1'b1);
    send_text("<", 1'b1);
    send_text("/", 1'b0);
    send_byte(stok_pkg::CH_NUL, 1'b1);
    send_text("!", 1'b1);
    send_text("0x", 1'b1);
    send_text("// c", 1'b1);
    send_byte(stok_pkg::CH_NUL, 1'b0);
    send_text("\n\n=", 1'b0);
    send_byte(stok_pkg::CH_NUL, 1'b0);
    send_text("x<@", 1'b1);
  endtask

  task automatic test_token_limit();
    write_token_limit(16'd1);
    send_text("a b c", 1'b0);
    send_byte(stok_pkg::CH_NUL, 1'b0);
    write_token_limit(16'd0);
    send_text("(", 1'b1);
    write_token_limit(16'd3);
    send_text("a b c d", 1'b1);
    send_text("x y<=z", 1'b0);
    send_byte(stok_pkg::CH_NUL, 1'b0);
    send_text("p q r", 1'b1);
    write_token_limit(16'hFFFF);
    send_text("a+b", 1'b1);
  endtask

  task automatic test_error_limit();
    write_token_limit(16'd3);
    repeat (70) send_byte("@", 1'b0);
    send_text("a b c", 1'b0);
    send_byte(stok_pkg::CH_NUL, 1'b0);
    send_text("@", 1'b1);
  endtask

  task automatic send_fragment();
    int n;
    case ($urandom_range(0, 13))
      0: send_text(kw_word[$urandom_range(0, stok_pkg::KW_COUNT - 1)], 1'b0);
      1, 2: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
        send_byte(name_pool[$urandom_range(0, 51)], 1'b0);
        repeat (n - 1) send_byte(name_pool[$urandom_range(0, name_pool.len() - 1)], 1'b0);
      end
      3: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 5);
        repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
      4: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
        send_byte("0", 1'b0);
        send_byte($urandom_range(0, 1) ? "x" : "X", 1'b0);
        repeat (n) send_byte(hex_pool[$urandom_range(0, hex_pool.len() - 1)], 1'b0);
      end
      5, 6: begin
        send_byte(op_pool[$urandom_range(0, op_pool.len() - 1)], 1'b0);
        if ($urandom_range(0, 1)) send_byte("=", 1'b0);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: send_byte(" ", 1'b0);
          1: send_byte(stok_pkg::CH_TAB, 1'b0);
          2: send_byte(stok_pkg::CH_VT, 1'b0);
          3: send_byte(stok_pkg::CH_FF, 1'b0);
          default: send_byte(stok_pkg::CH_CR, 1'b0);
        endcase
      end
      8: send_byte(stok_pkg::CH_LF, 1'b0);
      9: begin
        send_text("//", 1'b0);
        repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(1, 255)), 1'b0);
        send_byte(stok_pkg::CH_LF, 1'b0);
      end
      10: send_byte(8'($urandom_range(1, 255)), 1'b0);
      11: begin
        if ($urandom_range(0, 1)) send_byte(stok_pkg::CH_NUL, 1'($urandom_range(0, 1)));
        else send_byte(8'($urandom_range(1, 255)), 1'b1);
      end
      default: send_byte(" ", 1'b0);
    endcase
  endtask

  task automatic test_random();
    int goal;
    int base;
    logic [15:0] limit;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin limit = 16'hFFFF; goal = 20; end
        1: begin limit = 16'd1; goal = 4; end
        2: begin limit = 16'($urandom_range(2, 12)); goal = 10; end
        3: begin limit = 16'd0; goal = 4; end
        4: begin limit = stok_pkg::MAX_TOKENS_RESET; goal = 30; end
        default: begin limit = 16'($urandom_range(13, 60)); goal = 12; end
      endcase
      write_token_limit(limit);
      in_idle_pct = (phase == 4) ? 0 : 13;
      out_idle_pct = in_idle_pct;
      base = live_bytes;
      while (live_bytes - base < goal) send_fragment();
      send_byte(stok_pkg::CH_NUL, 1'b0);
    end
    in_idle_pct = 13;
    out_idle_pct = 13;
  endtask

  initial begin
    tok_limit = stok_pkg::MAX_TOKENS_RESET;
    source_restart();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_token_kinds();
    test_long_words();
    test_source_ends();
    test_token_limit();
    test_error_limit();
    test_random();
    drain_results();
    repeat (6) @(posedge clk);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("[source_tokenizer_core] OK");
    end else begin
      $display("[source_tokenizer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[source_tokenizer_core] ERROR");
    $finish;
  end

endmodule
